// ===== rtl/trs_pkg.sv =====
// Package for the task ready scheduler: command codes, sequencer states and
// the lowest-set-bit helper. No dependencies.
`default_nettype none
package trs_pkg;

    // Kernel command codes
    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_WAIT    = 3'd1,
        CMD_YIELD   = 3'd2,
        CMD_SET_RDY = 3'd3,
        CMD_CLR_RDY = 3'd4,
        CMD_TAKE    = 3'd5,
        CMD_RELEASE = 3'd6
    } t_cmd;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DISP  = 6'b000010,
        S_TRD   = 6'b000100,
        S_MRD   = 6'b001000,
        S_WRD   = 6'b010000,
        S_SCHED = 6'b100000
    } t_state;

    localparam logic [15:0] NEVER_COUNTS = 16'hFFFF;

    // Index of the lowest set bit, 0 for an empty mask
    function automatic logic [4:0] f_lowest(input logic [31:0] m);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/trs_if.sv =====
// Channel interfaces of the task ready scheduler: command beat in, result
// beat out. Depends on nothing.
`default_nettype none
interface trs_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [2:0]  task_id;
    logic [1:0]  mutex_id;
    logic [15:0] wait_ticks;
    logic [7:0]  elapsed;

    modport source (output valid, command, task_id, mutex_id, wait_ticks, elapsed,
                    input ready);
    modport sink (input valid, command, task_id, mutex_id, wait_ticks, elapsed,
                  output ready);
endinterface

interface trs_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] current_task;
    logic       running;
    logic       mutex_granted;
    logic       timed_out;
    logic [7:0] ready_bits;

    modport source (output valid, current_task, running, mutex_granted, timed_out,
                    ready_bits, input ready);
    modport sink (input valid, current_task, running, mutex_granted, timed_out,
                  ready_bits, output ready);
endinterface
`default_nettype wire

// ===== rtl/task_ready_scheduler_with_mutexes.sv =====
// Top level of the task ready scheduler: command sequencer around the sleep
// counter RAM and the mutex waiter RAM. Uses trs_pkg, trs_if and trs_ram.
//
//  channel | dir | beat fields
//  i_cmd   | in  | command, task_id, mutex_id, wait_ticks, elapsed
//  o_res   | out | current_task, running, mutex_granted, timed_out, ready_bits
//
// One command at a time. Wait, yield, set/clear ready, a granted take and any
// command but tick from an idle unit go from dispatch straight to scheduling.
// A blocking take or a release by a running task adds one waiter RAM
// read-modify-write. Tick walks the sleep count of each task in turn and,
// for each task that expires, the waiter masks; the single read port of each
// RAM sets this walk. Synchronous reset; sleep counts and waiter masks read as
// zero until first written (per-entry valid bits). A new command may be taken
// while the last result waits; its own result is then held in the final state
// until the waiting one has left.
`default_nettype none
module task_ready_scheduler_with_mutexes #(
    parameter int TASK_COUNT  = 8,
    parameter int MUTEX_COUNT = 4
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    trs_in_if.sink   i_cmd,
    trs_out_if.source o_res
);
    import trs_pkg::*;

    localparam int TW = TASK_COUNT > 1 ? $clog2(TASK_COUNT) : 1;
    localparam int MW = MUTEX_COUNT > 1 ? $clog2(MUTEX_COUNT) : 1;

    // Control state
    t_state                 r_state, n_state;
    logic [TASK_COUNT-1:0]  r_ready, n_ready;
    logic [TW-1:0]          r_run, n_run;
    logic                   r_idle, n_idle;
    logic [TASK_COUNT-1:0]  r_tmo, n_tmo;
    logic [MUTEX_COUNT-1:0] r_free, n_free;
    logic [TASK_COUNT-1:0]  r_sv, n_sv;
    logic [MUTEX_COUNT-1:0] r_wv, n_wv;
    logic [TW-1:0]          r_i, n_i;
    logic [MW-1:0]          r_k, n_k;
    logic                   r_gnt, n_gnt;
    logic                   r_o_valid, n_o_valid;

    // Latched command beat
    t_cmd        r_cmd;
    logic [2:0]  r_tid;
    logic [1:0]  r_mid;
    logic [15:0] r_wt;
    logic [7:0]  r_el;

    // Result payload
    logic [2:0] r_o_task, n_o_task;
    logic       r_o_run, n_o_run;
    logic       r_o_gnt, n_o_gnt;
    logic       r_o_tmo, n_o_tmo;
    logic [7:0] r_o_rdy, n_o_rdy;

    // RAM ports
    logic                  s_we, w_we;
    logic [TW-1:0]         s_waddr, s_raddr;
    logic [15:0]           s_wdata, s_q;
    logic [MW-1:0]         w_waddr, w_raddr;
    logic [TASK_COUNT-1:0] w_wdata, w_q;

    trs_ram #(.WIDTH(16), .DEPTH(TASK_COUNT)) u_sleep (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_q)
    );

    trs_ram #(.WIDTH(TASK_COUNT), .DEPTH(MUTEX_COUNT)) u_waiter (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_q)
    );

    logic                  acc;
    logic                  active, mutex_ok, tid_ok, do_sched, last_task;
    logic [MW-1:0]         mid_ix;
    logic [TW-1:0]         tid_ix, low_w, low_r;
    logic [TASK_COUNT-1:0] mybit, ibit, w_cur, w_rel;
    logic [15:0]           s_cur, s_dec;

    assign acc       = i_cmd.valid && i_cmd.ready;
    assign active    = !r_idle;
    assign mid_ix    = MW'(r_mid);
    assign tid_ix    = TW'(r_tid);
    assign mutex_ok  = 32'(r_mid) < MUTEX_COUNT;
    assign tid_ok    = 32'(r_tid) < TASK_COUNT;
    assign mybit     = TASK_COUNT'(1) << r_run;
    assign ibit      = TASK_COUNT'(1) << r_i;
    assign last_task = 32'(r_i) == TASK_COUNT - 1;
    // Entries never written read as zero
    assign s_cur     = r_sv[r_i] ? s_q : 16'd0;
    assign s_dec     = (s_cur <= {8'd0, r_el}) ? 16'd0 : s_cur - {8'd0, r_el};
    assign w_cur     = (r_state == S_MRD) ? (r_wv[r_k] ? w_q : '0)
                                          : (r_wv[mid_ix] ? w_q : '0);
    assign w_rel     = w_cur & ~mybit;
    assign low_w     = TW'(f_lowest(32'(w_rel)));
    assign low_r     = TW'(f_lowest(32'(n_ready)));
    assign do_sched  = r_idle || r_cmd == CMD_WAIT || r_cmd == CMD_YIELD ||
                       r_cmd == CMD_TAKE || r_cmd == CMD_RELEASE;

    assign i_cmd.ready         = (r_state == S_IDLE);
    assign o_res.valid         = r_o_valid;
    assign o_res.current_task  = r_o_task;
    assign o_res.running       = r_o_run;
    assign o_res.mutex_granted = r_o_gnt;
    assign o_res.timed_out     = r_o_tmo;
    assign o_res.ready_bits    = r_o_rdy;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_ready   = r_ready;
        n_run     = r_run;
        n_idle    = r_idle;
        n_tmo     = r_tmo;
        n_free    = r_free;
        n_sv      = r_sv;
        n_wv      = r_wv;
        n_i       = r_i;
        n_k       = r_k;
        n_gnt     = r_gnt;
        n_o_valid = r_o_valid && !o_res.ready;
        n_o_task  = r_o_task;
        n_o_run   = r_o_run;
        n_o_gnt   = r_o_gnt;
        n_o_tmo   = r_o_tmo;
        n_o_rdy   = r_o_rdy;
        s_we      = 1'b0;
        s_waddr   = r_run;
        s_wdata   = r_wt;
        s_raddr   = r_i;
        w_we      = 1'b0;
        w_waddr   = mid_ix;
        w_wdata   = w_rel;
        w_raddr   = mid_ix;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_gnt   = 1'b0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_SCHED;
                unique case (r_cmd)
                    CMD_TICK: begin
                        n_i     = '0;
                        s_raddr = '0;
                        n_state = S_TRD;
                    end
                    CMD_WAIT: begin
                        if (active) begin
                            s_we           = 1'b1;
                            n_sv[r_run]    = 1'b1;
                            n_ready[r_run] = 1'b0;
                        end
                    end
                    CMD_SET_RDY: begin
                        if (tid_ok) n_ready[tid_ix] = 1'b1;
                    end
                    CMD_CLR_RDY: begin
                        if (tid_ok) n_ready[tid_ix] = 1'b0;
                    end
                    CMD_TAKE: begin
                        if (active && mutex_ok) begin
                            if (r_free[mid_ix]) begin
                                n_free[mid_ix] = 1'b0;
                                n_gnt          = 1'b1;
                            end else begin
                                n_state = S_WRD;
                            end
                        end
                    end
                    CMD_RELEASE: begin
                        if (active && mutex_ok) n_state = S_WRD;
                    end
                    default: ;
                endcase
            end
            // Tick walk: sleep count of task r_i is on the read port
            S_TRD: begin
                if (s_cur != 16'd0 && s_cur != NEVER_COUNTS && !r_ready[r_i]) begin
                    s_we      = 1'b1;
                    s_waddr   = r_i;
                    s_wdata   = s_dec;
                    n_sv[r_i] = 1'b1;
                end
                if (s_cur != 16'd0 && s_cur != NEVER_COUNTS && !r_ready[r_i] &&
                    s_dec == 16'd0) begin
                    n_k     = '0;
                    w_raddr = '0;
                    n_state = S_MRD;
                end else if (last_task) begin
                    n_state = S_SCHED;
                end else begin
                    n_i     = r_i + 1'b1;
                    s_raddr = r_i + 1'b1;
                end
            end
            // Expired task: look for the lowest mutex it waits on
            S_MRD: begin
                if (w_cur[r_i] || 32'(r_k) == MUTEX_COUNT - 1) begin
                    if (w_cur[r_i]) begin
                        w_we       = 1'b1;
                        w_waddr    = r_k;
                        w_wdata    = w_cur & ~ibit;
                        n_wv[r_k]  = 1'b1;
                        n_tmo[r_i] = 1'b1;
                    end
                    n_ready[r_i] = 1'b1;
                    if (last_task) begin
                        n_state = S_SCHED;
                    end else begin
                        n_i     = r_i + 1'b1;
                        s_raddr = r_i + 1'b1;
                        n_state = S_TRD;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    w_raddr = r_k + 1'b1;
                end
            end
            // Waiter mask of r_mid is on the read port
            S_WRD: begin
                w_we         = 1'b1;
                n_wv[mid_ix] = 1'b1;
                if (r_cmd == CMD_TAKE) begin
                    w_wdata        = w_cur | mybit;
                    n_ready[r_run] = 1'b0;
                    s_we           = 1'b1;
                    n_sv[r_run]    = 1'b1;
                end else if (w_rel != '0) begin
                    s_we           = 1'b1;
                    s_waddr        = low_w;
                    s_wdata        = 16'd0;
                    n_sv[low_w]    = 1'b1;
                    n_ready[low_w] = 1'b1;
                    n_free[mid_ix] = 1'b0;
                end else begin
                    n_free[mid_ix] = 1'b1;
                end
                n_state = S_SCHED;
            end
            // Reschedule and load the result register
            S_SCHED: begin
                if (!r_o_valid || o_res.ready) begin
                    n_o_tmo = 1'b0;
                    if (do_sched) begin
                        if (n_ready == '0) begin
                            n_idle = 1'b1;
                        end else begin
                            n_run        = low_r;
                            n_idle       = 1'b0;
                            n_o_tmo      = r_tmo[low_r];
                            n_tmo[low_r] = 1'b0;
                        end
                    end
                    n_o_valid = 1'b1;
                    n_o_task  = n_idle ? 3'd0 : 3'(n_run);
                    n_o_run   = !n_idle;
                    n_o_gnt   = r_gnt;
                    n_o_rdy   = 8'(n_ready);
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ready   <= '0;
            r_run     <= '0;
            r_idle    <= 1'b1;
            r_tmo     <= '0;
            r_free    <= '1;
            r_sv      <= '0;
            r_wv      <= '0;
            r_i       <= '0;
            r_k       <= '0;
            r_gnt     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ready   <= n_ready;
            r_run     <= n_run;
            r_idle    <= n_idle;
            r_tmo     <= n_tmo;
            r_free    <= n_free;
            r_sv      <= n_sv;
            r_wv      <= n_wv;
            r_i       <= n_i;
            r_k       <= n_k;
            r_gnt     <= n_gnt;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cmd <= t_cmd'(i_cmd.command);
            r_tid <= i_cmd.task_id;
            r_mid <= i_cmd.mutex_id;
            r_wt  <= i_cmd.wait_ticks;
            r_el  <= i_cmd.elapsed;
        end
        r_o_task <= n_o_task;
        r_o_run  <= n_o_run;
        r_o_gnt  <= n_o_gnt;
        r_o_tmo  <= n_o_tmo;
        r_o_rdy  <= n_o_rdy;
    end
endmodule
`default_nettype wire

// ===== rtl/trs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module trs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/trs_checker.sv =====
// Port-level checks on the task ready scheduler, bound to the top level.
// Depends on the top level's channel ports only.
`default_nettype none
module trs_port_checks (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_task,
    input wire logic       i_running,
    input wire logic       i_timed_out
);
    // A result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // One command at a time: no beat right after an accepted one
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted back to back");

    // Idle result reports task zero
    a_idle_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_running |-> i_task == 3'd0)
        else $error("idle result with nonzero task");

    // A timeout is only reported for a scheduled task
    a_tmo_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_timed_out |-> i_running)
        else $error("timeout reported while idle");
endmodule

bind task_ready_scheduler_with_mutexes trs_port_checks u_trs_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_task      (o_res.current_task),
    .i_running   (o_res.running),
    .i_timed_out (o_res.timed_out)
);
`default_nettype wire

// ===== tb/trs_checker.sv =====
// Checker for the task ready scheduler: watches the command and result
// channels, predicts each result beat and compares. Uses trs_pkg and trs_if.
module trs_checker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    trs_in_if.sink     i_cmd,
    trs_out_if.sink    o_res,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import trs_pkg::*;

    localparam int NTASK = 8;
    localparam int NMUTEX = 4;

    typedef struct packed {
        logic [2:0] cur;
        logic       run;
        logic       granted;
        logic       tmo;
        logic [7:0] rdy;
    } t_sched_res;

    // kernel state copy
    logic [7:0]  rdy_mask;
    logic [2:0]  cur_task;
    logic        is_idle;
    logic [15:0] sleep_cnt [NTASK];
    logic        tmo_flag [NTASK];
    logic [7:0]  waiters [NMUTEX];
    logic [2:0]  owner [NMUTEX];
    logic        mfree [NMUTEX];

    t_sched_res expected_q[$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending = expected_q.size();

    function automatic logic [2:0] low_idx(input logic [7:0] m);
        for (int i = 0; i < 8; i++) if (m[i]) return 3'(i);
        return 3'd0;
    endfunction

    function automatic logic pick_task();
        if (rdy_mask == 8'd0) begin
            is_idle = 1'b1;
            return 1'b0;
        end
        cur_task = low_idx(rdy_mask);
        is_idle = 1'b0;
        if (tmo_flag[cur_task]) begin
            tmo_flag[cur_task] = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void count_down(input logic [7:0] el);
        logic [15:0] c;
        for (int i = 0; i < NTASK; i++) begin
            c = sleep_cnt[i];
            if (c == 16'd0 || c == NEVER_COUNTS || rdy_mask[i]) continue;
            c = (c <= el) ? 16'd0 : c - el;
            sleep_cnt[i] = c;
            if (c != 16'd0) continue;
            for (int k = 0; k < NMUTEX; k++) begin
                if (waiters[k][i]) begin
                    waiters[k][i] = 1'b0;
                    tmo_flag[i] = 1'b1;
                    break;
                end
            end
            rdy_mask[i] = 1'b1;
        end
    endfunction

    function automatic t_sched_res run_command(input logic [2:0] cmd, input logic [2:0] tid,
                                               input logic [1:0] mid, input logic [15:0] wt,
                                               input logic [7:0] el);
        t_sched_res r;
        logic [2:0] me;
        logic active, sched;
        me = cur_task;
        active = !is_idle;
        sched = 1'b1;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                count_down(el);
                sched = is_idle;
            end
            CMD_WAIT: if (active) begin
                sleep_cnt[me] = wt;
                rdy_mask[me] = 1'b0;
            end
            CMD_YIELD: ;
            CMD_SET_RDY: begin
                rdy_mask[tid] = 1'b1;
                sched = is_idle;
            end
            CMD_CLR_RDY: begin
                rdy_mask[tid] = 1'b0;
                sched = is_idle;
            end
            CMD_TAKE: if (active) begin
                if (mfree[mid]) begin
                    mfree[mid] = 1'b0;
                    owner[mid] = me;
                    r.granted = 1'b1;
                end else begin
                    waiters[mid][me] = 1'b1;
                    rdy_mask[me] = 1'b0;
                    sleep_cnt[me] = wt;
                end
            end
            CMD_RELEASE: if (active) begin
                waiters[mid][me] = 1'b0;
                if (waiters[mid] != 8'd0) begin
                    owner[mid] = low_idx(waiters[mid]);
                    mfree[mid] = 1'b0;
                    sleep_cnt[owner[mid]] = 16'd0;
                    rdy_mask[owner[mid]] = 1'b1;
                end else begin
                    mfree[mid] = 1'b1;
                    owner[mid] = 3'd0;
                end
            end
            default: sched = is_idle;
        endcase
        if (sched) r.tmo = pick_task();
        r.cur = is_idle ? 3'd0 : cur_task;
        r.run = !is_idle;
        r.rdy = rdy_mask;
        return r;
    endfunction

    // predict on each command beat, compare on each result beat
    always @(posedge i_clk) begin
        t_sched_res got, exp_r;
        if (!i_rst_n) begin
            cur_task = '0;
            is_idle = 1'b1;
            rdy_mask = '0;
            for (int i = 0; i < NTASK; i++) begin
                sleep_cnt[i] = '0;
                tmo_flag[i] = 1'b0;
            end
            for (int k = 0; k < NMUTEX; k++) begin
                waiters[k] = '0;
                owner[k] = '0;
                mfree[k] = 1'b1;
            end
            expected_q.delete();
            fails = 0;
        end else begin
            if (o_res.valid && o_res.ready) begin
                got = '{o_res.current_task, o_res.running, o_res.mutex_granted,
                        o_res.timed_out, o_res.ready_bits};
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    fails++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.cur !== exp_r.cur) begin
                        $error("current_task exp %0d got %0d", exp_r.cur, got.cur);
                        fails++;
                    end
                    if (got.run !== exp_r.run) begin
                        $error("running exp %0d got %0d", exp_r.run, got.run);
                        fails++;
                    end
                    if (got.granted !== exp_r.granted) begin
                        $error("mutex_granted exp %0d got %0d", exp_r.granted, got.granted);
                        fails++;
                    end
                    if (got.tmo !== exp_r.tmo) begin
                        $error("timed_out exp %0d got %0d", exp_r.tmo, got.tmo);
                        fails++;
                    end
                    if (got.rdy !== exp_r.rdy) begin
                        $error("ready_bits exp %h got %h", exp_r.rdy, got.rdy);
                        fails++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                expected_q.push_back(run_command(i_cmd.command, i_cmd.task_id,
                    i_cmd.mutex_id, i_cmd.wait_ticks, i_cmd.elapsed));
        end
    end
endmodule

// ===== tb/testbench.sv =====
// Testbench top for the task ready scheduler: clock, reset, command stimulus,
// result back-pressure and verdict. Uses trs_pkg, trs_if and trs_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import trs_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int NUM_RANDOM = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, quiet_cycles;
    logic stall_mode;

    trs_in_if  cmd_ch ();
    trs_out_if res_ch ();

    task_ready_scheduler_with_mutexes dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_ch.sink), .o_res(res_ch.source)
    );

    trs_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_ch.sink), .o_res(res_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stall pattern: phases of no stall and of heavy stall
    initial begin
        res_ch.ready = 1'b0;
        stall_mode = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
            res_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one command beat; valid stays high across back-to-back beats
    task automatic send_beat(input logic [2:0] cmd, input logic [2:0] tid,
                             input logic [1:0] mid, input logic [15:0] wt,
                             input logic [7:0] el);
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.task_id <= tid;
        cmd_ch.mutex_id <= mid;
        cmd_ch.wait_ticks <= wt;
        cmd_ch.elapsed <= el;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int n);
        cmd_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // mostly short waits so expiries happen often; sometimes forever or max
    function automatic logic [15:0] pick_wait();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'd0;
        if (sel == 1) return 16'hFFFE;
        if (sel == 2) return 16'($urandom);
        return 16'($urandom_range(1, 40));
    endfunction

    initial begin
        int burst;
        logic [2:0] cmd;
        quiet_cycles = 0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_TICK;
        cmd_ch.task_id = '0;
        cmd_ch.mutex_id = '0;
        cmd_ch.wait_ticks = '0;
        cmd_ch.elapsed = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle commands, every task ready, mutex contention,
        // timeouts, release handoff, forever waits and extreme fields
        send_beat(CMD_TICK, 3'd0, 2'd0, 16'd0, 8'hFF);
        send_beat(CMD_WAIT, 3'd7, 2'd3, 16'hFFFF, 8'd0);
        send_beat(CMD_TAKE, 3'd0, 2'd1, 16'd5, 8'd0);
        send_beat(CMD_RELEASE, 3'd0, 2'd1, 16'd5, 8'd0);
        send_beat(3'd7, 3'd0, 2'd0, 16'd0, 8'd0);
        for (int t = 0; t < 8; t++) send_beat(CMD_SET_RDY, 3'(t), 2'd0, 16'd0, 8'd0);
        send_beat(CMD_TAKE, 3'd0, 2'd2, 16'd10, 8'd0);
        send_beat(CMD_TAKE, 3'd0, 2'd2, 16'd10, 8'd0);
        send_beat(CMD_TAKE, 3'd1, 2'd2, 16'd0, 8'd0);
        send_beat(CMD_TAKE, 3'd2, 2'd2, 16'd3, 8'd0);
        send_beat(CMD_WAIT, 3'd3, 2'd0, 16'hFFFF, 8'd0);
        send_beat(CMD_WAIT, 3'd4, 2'd0, 16'd1, 8'd0);
        send_beat(CMD_TICK, 3'd0, 2'd0, 16'd0, 8'd4);
        send_beat(CMD_YIELD, 3'd0, 2'd0, 16'd0, 8'd0);
        send_beat(CMD_RELEASE, 3'd0, 2'd2, 16'd0, 8'd0);
        send_beat(CMD_TICK, 3'd0, 2'd0, 16'd0, 8'd255);
        send_beat(CMD_CLR_RDY, 3'd7, 2'd0, 16'd0, 8'd0);
        send_beat(3'd7, 3'd0, 2'd3, 16'hFFFF, 8'hFF);

        // wait for every expected result before the random part
        pause_sender(1);
        while (pending != 0) @(posedge i_clk);

        // random bursts with gaps
        for (int n = 0; n < NUM_RANDOM;) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < NUM_RANDOM; b++, n++) begin
                cmd = 3'($urandom_range(0, 12));
                if (cmd > 3'd6 || $urandom_range(0, 12) > 6) begin
                    case ($urandom_range(0, 5))
                        0, 1: cmd = CMD_TICK;
                        2, 3: cmd = CMD_SET_RDY;
                        4: cmd = CMD_TAKE;
                        default: cmd = CMD_RELEASE;
                    endcase
                end
                if ($urandom_range(0, 40) == 0) cmd = 3'd7;
                send_beat(cmd, 3'($urandom), 2'($urandom), pick_wait(),
                          ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 30));
        end
        cmd_ch.valid <= 1'b0;

        // drain and let the block settle
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
